/* rtl/pfp_pkg.sv */
// ============================================================================
// pfp_pkg
// Shared types and constants for the panel frame parser with acknowledge.
// ============================================================================
package pfp_pkg;

    // Command and subcommand codes
    localparam logic [7:0] CMD_SUB_A   = 8'h80;
    localparam logic [7:0] CMD_SUB_B   = 8'h81;
    localparam logic [7:0] CMD_ACK     = 8'h40;
    localparam logic [7:0] SUB_RESET   = 8'h01;
    localparam logic [7:0] SUB_CHAR    = 8'h03;

    // Acknowledge bytes sent back at frame end
    localparam logic [7:0] TX_ACK_HEAD = 8'h02;
    localparam logic [7:0] TX_ACK_TAIL = 8'h40;

    localparam int TOTAL_W = 16;

    // Receive phase, one-hot
    typedef enum logic [3:0] {
        PH_LENGTH     = 4'b0001,
        PH_COMMAND    = 4'b0010,
        PH_SUBCOMMAND = 4'b0100,
        PH_DATA       = 4'b1000
    } phase_t;

    // Frame-end event passed from the parser to the result sequencer
    typedef struct packed {
        logic               two_acks;
        logic               reset_req;
        logic               char_valid;
        logic [7:0]         char_value;
        logic [TOTAL_W-1:0] ack_total;
    } pfp_event_t;

endpackage

/* rtl/pfp_front.sv */
// ============================================================================
// pfp_front
// Byte parser: tracks frame phase and length, emits one event per frame end.
// ============================================================================
module pfp_front #(
    parameter int ACK_COUNT_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    output logic               ev_push,
    output pfp_pkg::pfp_event_t ev_data
);

    localparam int XW = (ACK_COUNT_WIDTH > pfp_pkg::TOTAL_W) ?
                        ACK_COUNT_WIDTH : pfp_pkg::TOTAL_W;

    pfp_pkg::phase_t              phase_reg, phase_next;
    logic [7:0]                   left_reg, left_next;
    logic [7:0]                   cmd_reg, cmd_next;
    logic [7:0]                   sub_reg, sub_next;
    logic [ACK_COUNT_WIDTH-1:0]   ack_reg, ack_next;

    logic [7:0]                   left_base;
    logic [7:0]                   left_dec;
    logic [7:0]                   cmd_cur;
    logic [7:0]                   sub_cur;
    logic                         done;
    logic                         is_ack;
    logic                         chv;
    logic [ACK_COUNT_WIDTH-1:0]   ack_inc;
    logic [XW-1:0]                ack_ext;

    // Field capture by phase
    always_comb
    begin
        left_base = left_reg;
        cmd_cur   = cmd_reg;
        sub_cur   = sub_reg;
        phase_next = phase_reg;
        case (phase_reg)
            pfp_pkg::PH_LENGTH:
            begin
                left_base  = rx_byte;
                phase_next = pfp_pkg::PH_COMMAND;
            end
            pfp_pkg::PH_COMMAND:
            begin
                cmd_cur = rx_byte;
                sub_cur = 8'h00;
                if (rx_byte == pfp_pkg::CMD_SUB_A || rx_byte == pfp_pkg::CMD_SUB_B)
                    phase_next = pfp_pkg::PH_SUBCOMMAND;
                else
                    phase_next = pfp_pkg::PH_DATA;
            end
            pfp_pkg::PH_SUBCOMMAND:
            begin
                sub_cur    = rx_byte;
                phase_next = pfp_pkg::PH_DATA;
            end
            pfp_pkg::PH_DATA:
            begin
                phase_next = pfp_pkg::PH_DATA;
            end
            default:
            begin
                phase_next = pfp_pkg::PH_LENGTH;
            end
        endcase

        left_dec = left_base - 8'd1;
        done     = (left_dec == 8'd0);
        is_ack   = (cmd_cur == pfp_pkg::CMD_ACK);
        chv      = (sub_cur == pfp_pkg::SUB_CHAR);
        ack_inc  = ack_reg + ACK_COUNT_WIDTH'(1);

        left_next = left_dec;
        cmd_next  = cmd_cur;
        sub_next  = sub_cur;
        ack_next  = ack_reg;
        if (done)
        begin
            phase_next = pfp_pkg::PH_LENGTH;
            if (is_ack)
                ack_next = ack_inc;
            // character delivery returns the parser to a fresh frame context
            if (chv)
            begin
                cmd_next = 8'h00;
                sub_next = 8'h00;
            end
        end
    end

    // Event record for the frame that ends on this item
    assign ack_ext                = XW'(ack_next);
    assign ev_push                = accept && done;
    assign ev_data.two_acks       = !is_ack;
    assign ev_data.reset_req      = (sub_cur == pfp_pkg::SUB_RESET);
    assign ev_data.char_valid     = chv;
    assign ev_data.char_value     = chv ? rx_byte : 8'h00;
    assign ev_data.ack_total      = ack_ext[pfp_pkg::TOTAL_W-1:0];

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pfp_pkg::PH_LENGTH;
            left_reg  <= 8'h00;
            cmd_reg   <= 8'h00;
            sub_reg   <= 8'h00;
            ack_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            cmd_reg   <= cmd_next;
            sub_reg   <= sub_next;
            ack_reg   <= ack_next;
        end
    end

endmodule

/* rtl/pfp_queue.sv */
// ============================================================================
// pfp_queue
// Two-entry event queue between the parser and the result sequencer.
// ============================================================================
module pfp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  pfp_pkg::pfp_event_t wr_data,
    input  logic                rd_en,
    output pfp_pkg::pfp_event_t rd_data,
    output logic                q_empty,
    output logic                q_full
);

    pfp_pkg::pfp_event_t slot_reg [2];
    logic                wptr_reg;
    logic                rptr_reg;
    logic [1:0]          count_reg, count_next;

    assign rd_data = slot_reg[rptr_reg];
    assign q_empty = (count_reg == 2'd0);
    assign q_full  = (count_reg == 2'd2);

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 2'd1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 2'd1;
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wptr_reg <= !wptr_reg;
            if (rd_en)
                rptr_reg <= !rptr_reg;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wptr_reg] <= wr_data;
    end

endmodule

/* rtl/pfp_back.sv */
// ============================================================================
// pfp_back
// Result sequencer: expands each event into one or two result items.
// ============================================================================
module pfp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  pfp_pkg::pfp_event_t ev_data,
    input  logic                ev_empty,
    output logic                ev_pop,
    input  logic                pop,
    output logic                empty,
    output logic                tx_valid,
    output logic [7:0]          tx_byte,
    output logic                last,
    output logic                frame_done,
    output logic                reset_request,
    output logic                char_valid,
    output logic [7:0]          char_value,
    output logic [15:0]         ack_total
);

    logic        out_valid_reg;
    logic        pend_reg;
    logic        tx_valid_reg;
    logic [7:0]  tx_byte_reg;
    logic        last_reg;
    logic        rst_req_reg;
    logic        chv_reg;
    logic [7:0]  chval_reg;
    logic [15:0] total_reg;
    logic        can_load;

    // Output slot frees when empty or when its item is taken
    assign can_load = !out_valid_reg || pop;
    assign ev_pop   = can_load && !pend_reg && !ev_empty;

    assign empty         = !out_valid_reg;
    assign tx_valid      = tx_valid_reg;
    assign tx_byte       = tx_byte_reg;
    assign last          = last_reg;
    assign frame_done    = out_valid_reg;
    assign reset_request = rst_req_reg;
    assign char_valid    = chv_reg;
    assign char_value    = chval_reg;
    assign ack_total     = total_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (can_load)
        begin
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end
            else if (!ev_empty)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= ev_data.two_acks;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload; second acknowledge byte reuses the held frame fields
    always_ff @(posedge clk)
    begin
        if (can_load)
        begin
            if (pend_reg)
            begin
                tx_byte_reg <= pfp_pkg::TX_ACK_TAIL;
                last_reg    <= 1'b1;
            end
            else if (!ev_empty)
            begin
                tx_valid_reg <= ev_data.two_acks;
                tx_byte_reg  <= ev_data.two_acks ? pfp_pkg::TX_ACK_HEAD : 8'h00;
                last_reg     <= !ev_data.two_acks;
                rst_req_reg  <= ev_data.reset_req;
                chv_reg      <= ev_data.char_valid;
                chval_reg    <= ev_data.char_value;
                total_reg    <= ev_data.ack_total;
            end
        end
    end

endmodule

/* rtl/panel_frame_parser_ack.sv */
// ============================================================================
// panel_frame_parser_ack
// Length-prefixed frame parser that counts acknowledge frames and emits
// acknowledge bytes, reset requests and delivered characters at frame end.
// ============================================================================
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | push / full        | rx_byte
//  result   | empty / pop        | tx_valid tx_byte last frame_done
//           |                    | reset_request char_valid char_value ack_total
//
// One byte is parsed per cycle while full is low; a frame end queues an event in
// a two-entry queue, which the sequencer turns into one result (acknowledge
// frame) or two (0x02 then 0x40). An accepted frame end is written to the event
// queue, then loaded into the sequencer's output register, which drives empty low.
// Reset clears phase, length, command, subcommand and the acknowledge count.
// full rises while the event queue holds two events; pop low stalls the
// sequencer, and while full is high no byte is taken.
module panel_frame_parser_ack #(
    parameter int ACK_COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic        frame_done,
    output logic        reset_request,
    output logic        char_valid,
    output logic [7:0]  char_value,
    output logic [15:0] ack_total
);

    logic                accept;
    logic                ev_push;
    logic                ev_pop;
    logic                q_empty;
    logic                q_full;
    pfp_pkg::pfp_event_t ev_in;
    pfp_pkg::pfp_event_t ev_out;

    assign full   = q_full;
    assign accept = push && !q_full;

    pfp_front #(
        .ACK_COUNT_WIDTH (ACK_COUNT_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .ev_push (ev_push),
        .ev_data (ev_in)
    );

    pfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ev_push),
        .wr_data (ev_in),
        .rd_en   (ev_pop),
        .rd_data (ev_out),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    pfp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .ev_data       (ev_out),
        .ev_empty      (q_empty),
        .ev_pop        (ev_pop),
        .pop           (pop),
        .empty         (empty),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .last          (last),
        .frame_done    (frame_done),
        .reset_request (reset_request),
        .char_valid    (char_valid),
        .char_value    (char_value),
        .ack_total     (ack_total)
    );

endmodule

/* tb/panel_frame_parser_ack_checker.sv */
// ============================================================================
// panel_frame_parser_ack_checker
// Watches the receive and acknowledge channels of the frame parser, tracks
// the frame state of the received byte stream, and checks every result
// against the acknowledge replies that the stream calls for, in order.
// ============================================================================
module panel_frame_parser_ack_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic        tx_valid,
    input  logic [7:0]  tx_byte,
    input  logic        last,
    input  logic        frame_done,
    input  logic        reset_request,
    input  logic        char_valid,
    input  logic [7:0]  char_value,
    input  logic [15:0] ack_total,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                        tx_valid;
        logic [7:0]                  tx_byte;
        logic                        last;
        logic                        frame_done;
        logic                        reset_request;
        logic                        char_valid;
        logic [7:0]                  char_value;
        logic [pfp_pkg::TOTAL_W-1:0] ack_total;
    } ack_reply_t;

    // Replies owed by the block, oldest first
    ack_reply_t                  ack_reply_q[$];

    // Frame state tracked from the accepted bytes
    pfp_pkg::phase_t             rx_phase;
    logic [7:0]                  bytes_left;
    logic [7:0]                  cur_cmd;
    logic [7:0]                  cur_sub;
    logic [pfp_pkg::TOTAL_W-1:0] ack_count;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // Advance the frame state by one byte and queue the replies of a frame end
    task automatic parse_rx_byte(input logic [7:0] b);
        ack_reply_t r;
        int         n;
        case (rx_phase)
            pfp_pkg::PH_LENGTH:
            begin
                bytes_left = b;
                rx_phase   = pfp_pkg::PH_COMMAND;
            end
            pfp_pkg::PH_COMMAND:
            begin
                cur_cmd  = b;
                cur_sub  = 8'h00;
                rx_phase = (b == pfp_pkg::CMD_SUB_A || b == pfp_pkg::CMD_SUB_B) ?
                           pfp_pkg::PH_SUBCOMMAND : pfp_pkg::PH_DATA;
            end
            pfp_pkg::PH_SUBCOMMAND:
            begin
                cur_sub  = b;
                rx_phase = pfp_pkg::PH_DATA;
            end
            default:
            begin
            end
        endcase

        // a length byte of zero wraps here into a 256-byte frame
        bytes_left = bytes_left - 8'd1;
        if (bytes_left != 8'd0)
            return;

        rx_phase = pfp_pkg::PH_LENGTH;
        if (cur_cmd == pfp_pkg::CMD_ACK)
        begin
            ack_count = ack_count + 1'b1;
            n = 1;
        end
        else
        begin
            n = 2;
        end

        r.frame_done    = 1'b1;
        r.reset_request = (cur_sub == pfp_pkg::SUB_RESET);
        r.char_valid    = (cur_sub == pfp_pkg::SUB_CHAR);
        r.char_value    = r.char_valid ? b : 8'h00;
        r.ack_total     = ack_count;
        for (int k = 0; k < n; k++)
        begin
            r.tx_valid = (n == 2);
            r.tx_byte  = (n == 2) ?
                         ((k == 0) ? pfp_pkg::TX_ACK_HEAD : pfp_pkg::TX_ACK_TAIL) : 8'h00;
            r.last     = (k == n - 1);
            ack_reply_q.push_back(r);
        end

        // a delivered character leaves the parser as fresh
        if (r.char_valid)
        begin
            cur_cmd = 8'h00;
            cur_sub = 8'h00;
        end
    endtask

    // Compare the result taken at this edge with the oldest reply owed
    task automatic check_reply();
        ack_reply_t want;
        if (ack_reply_q.size() == 0)
        begin
            report_mismatch($sformatf("result with no reply owed: tx_byte 0x%0h ack_total %0d",
                                      tx_byte, ack_total));
            return;
        end
        want = ack_reply_q.pop_front();
        if (tx_valid !== want.tx_valid)
            report_mismatch($sformatf("tx_valid got %0b expected %0b", tx_valid, want.tx_valid));
        if (tx_byte !== want.tx_byte)
            report_mismatch($sformatf("tx_byte got 0x%0h expected 0x%0h", tx_byte, want.tx_byte));
        if (last !== want.last)
            report_mismatch($sformatf("last got %0b expected %0b", last, want.last));
        if (frame_done !== want.frame_done)
            report_mismatch($sformatf("frame_done got %0b expected %0b",
                                      frame_done, want.frame_done));
        if (reset_request !== want.reset_request)
            report_mismatch($sformatf("reset_request got %0b expected %0b",
                                      reset_request, want.reset_request));
        if (char_valid !== want.char_valid)
            report_mismatch($sformatf("char_valid got %0b expected %0b",
                                      char_valid, want.char_valid));
        if (char_value !== want.char_value)
            report_mismatch($sformatf("char_value got 0x%0h expected 0x%0h",
                                      char_value, want.char_value));
        if (ack_total !== want.ack_total)
            report_mismatch($sformatf("ack_total got %0d expected %0d",
                                      ack_total, want.ack_total));
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // Results first: nothing accepted at this edge can already be on the output
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase   = pfp_pkg::PH_LENGTH;
            bytes_left = 8'h00;
            cur_cmd    = 8'h00;
            cur_sub    = 8'h00;
            ack_count  = '0;
            ack_reply_q.delete();
        end
        else
        begin
            if (pop && !empty)
                check_reply();
            if (push && !full)
                parse_rx_byte(rx_byte);
        end
        pending = ack_reply_q.size();
    end

endmodule

/* tb/panel_frame_parser_ack_tb.sv */
// ============================================================================
// panel_frame_parser_ack_tb
// Feeds the frame parser a directed set of frames, then random frames of
// random length, command and subcommand with random gaps and result stalls,
// and one long result hold-off. A checker beside the block predicts and
// compares every result.
// ============================================================================
module panel_frame_parser_ack_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIRECTED_N   = 25;
    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_FRAMES  = 40;
    localparam int DRAIN_CYCLES = 10;

    // Header corners: frames ending on their length, command and subcommand
    // bytes, acknowledge frames, reset request, character delivery
    localparam logic [7:0] DIRECTED_BYTES [DIRECTED_N] = '{
        8'd1,
        8'd2, pfp_pkg::CMD_ACK,
        8'd3, pfp_pkg::CMD_SUB_A, pfp_pkg::SUB_RESET,
        8'd1,
        8'd4, pfp_pkg::CMD_SUB_B, pfp_pkg::SUB_CHAR, 8'hFF,
        8'd1,
        8'd2, pfp_pkg::CMD_SUB_A,
        8'd3, pfp_pkg::CMD_ACK, 8'h00,
        8'd5, 8'hFF, 8'hAA, 8'h55, 8'h00,
        8'd3, pfp_pkg::CMD_SUB_B, pfp_pkg::SUB_CHAR
    };

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        push    = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        pop     = 1'b0;
    logic        full;
    logic        empty;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic        frame_done;
    logic        reset_request;
    logic        char_valid;
    logic [7:0]  char_value;
    logic [15:0] ack_total;

    int          errors;
    int          pending;
    int          items_sent    = 0;
    bit          steady        = 1'b0;
    bit          hold_results  = 1'b0;
    bit          pressure_done = 1'b0;

    panel_frame_parser_ack dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .rx_byte       (rx_byte),
        .empty         (empty),
        .pop           (pop),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .last          (last),
        .frame_done    (frame_done),
        .reset_request (reset_request),
        .char_valid    (char_valid),
        .char_value    (char_value),
        .ack_total     (ack_total)
    );

    panel_frame_parser_ack_checker frame_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .rx_byte       (rx_byte),
        .empty         (empty),
        .pop           (pop),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .last          (last),
        .frame_done    (frame_done),
        .reset_request (reset_request),
        .char_valid    (char_valid),
        .char_value    (char_value),
        .ack_total     (ack_total),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver stall, same shape
    function automatic int pick_stall();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Short frames mostly; truncated headers and any length now and then
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 8'd1;
        if (r < 10)
            return 8'd2;
        if (r < 12)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(3, 12));
    endfunction

    function automatic logic [7:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return pfp_pkg::CMD_ACK;
        if (r < 50)
            return pfp_pkg::CMD_SUB_A;
        if (r < 70)
            return pfp_pkg::CMD_SUB_B;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_sub();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return pfp_pkg::SUB_RESET;
        if (r < 60)
            return pfp_pkg::SUB_CHAR;
        if (r < 70)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one byte, wait for it to be taken, then maybe idle;
    // push stays high when the next item follows at once
    task automatic send_rx(input logic [7:0] b);
        int gap;
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // One frame: length, command, subcommand where the command takes one, data
    task automatic send_frame(input logic [7:0] len);
        int         n;
        logic [7:0] cmd;
        n   = (len == 8'd0) ? 256 : len;
        cmd = pick_cmd();
        send_rx(len);
        for (int i = 1; i < n; i++)
        begin
            if (i == 1)
                send_rx(cmd);
            else if (i == 2 && (cmd == pfp_pkg::CMD_SUB_A || cmd == pfp_pkg::CMD_SUB_B))
                send_rx(pick_sub());
            else
                send_rx(8'($urandom_range(0, 255)));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_BYTES[i])
            send_rx(DIRECTED_BYTES[i]);

        // zero length byte: 256-byte frame
        send_frame(8'd0);

        while (items_sent < DIRECTED_N + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 5)
                steady = !steady;
            if (!pressure_done && items_sent > 500)
            begin
                // receiver holds off while single-byte frames pile up
                hold_results = 1'b1;
                repeat (HOLD_FRAMES) send_rx(8'd1);
                pressure_done = 1'b1;
            end
            send_frame(pick_len());
        end
        push <= 1'b0;

        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("panel_frame_parser_ack_tb: done, clean");
        else
            $display("panel_frame_parser_ack_tb: done, errors");
        $finish;
    end

    // Result side: random pop with stalls, plus the one long hold-off
    initial
    begin
        int stall;
        forever
        begin
            if (hold_results)
            begin
                stall        = HOLD_CYCLES;
                hold_results = 1'b0;
            end
            else
            begin
                stall = pick_stall();
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog on cycles in which no item moves on either side
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("panel_frame_parser_ack_tb: done, errors");
                $finish;
            end
        end
    end

endmodule

/* files.f */
rtl/pfp_pkg.sv
rtl/pfp_front.sv
rtl/pfp_queue.sv
rtl/pfp_back.sv
rtl/panel_frame_parser_ack.sv
tb/panel_frame_parser_ack_checker.sv
tb/panel_frame_parser_ack_tb.sv
